@@ hw/rtl/bdbl_pkg.sv @@
// ----------------------------------------------------------------------------
// bdbl_pkg
// Shared types and constants of the box downscaler with brightness level.
// ----------------------------------------------------------------------------
package bdbl_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_INVERT     = 3'd4;

  // register field widths
  localparam int SRC_REG_W = 11;
  localparam int DST_REG_W = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  // running column sums and the divide by block area
  localparam int SUM_W     = 28;
  localparam int DIV_STEPS = SUM_W;
  localparam int DCNT_W    = 5;

  // brightness thresholds on r+g+b out of 765
  localparam logic [9:0] LVL_T1 = 10'd191;
  localparam logic [9:0] LVL_T2 = 10'd382;
  localparam logic [9:0] LVL_T3 = 10'd573;
  localparam logic [1:0] LVL_MAX = 2'd3;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_UPD  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_OUT  = 7'b0001000,
    S_CLD  = 7'b0010000,
    S_CDIV = 7'b0100000,
    S_AREA = 7'b1000000
  } state_t;

  typedef logic [SUM_W-1:0] sum_t;

endpackage

@@ hw/rtl/box_downscale_brightness_level.sv @@
// ----------------------------------------------------------------------------
// box_downscale_brightness_level
// Box-filter area downscaler for an RGB raster stream with a 2-bit level.
// ----------------------------------------------------------------------------
// Input words: one source pixel each, raster order, in_tuser marks the first
// pixel of a frame. Output words: one averaged block each, sent when the
// bottom-right source pixel of a block has been taken; out_tlast marks the
// last block of the frame. Pixels outside every block give no word.
// Configuration: cfg_index/cfg_data written with cfg_valid/cfg_ready, only
// while no pixel is in flight. Each write starts a recompute of block size
// and step (two bit-serial dividers plus one multiply), busy through a load
// state, the divider steps and the area state, during which no pixel is taken.
// Each accepted pixel is followed by an update state (read-modify-write of
// the column-sum line store, one synchronous memory with a registered
// read); no new pixel is taken until it is done. A pixel that closes a block
// then runs the bit-serial divide by the block area and a state that loads
// the output register once it is free.
// The output register decouples a stalled receiver: the next pixels are
// still taken until another finished block finds the register full.
// Reset: registers go to 1x1 -> 1x1, positions to zero; the line store is
// not cleared (each block's first pixel overwrites its entry).
// ----------------------------------------------------------------------------
module box_downscale_brightness_level #(
  parameter int MAX_SRC_DIM = 1024,
  parameter int MAX_DST_DIM = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input pixel stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in, green_in, blue_in
  input  logic        in_tuser,   // frame_start
  // output block stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // 6'b0, bright_level, avg_red, avg_green, avg_blue
  output logic        out_tlast,  // frame_last
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bdbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdbl_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int SW_W = $clog2(MAX_SRC_DIM) + 1;
  localparam int SCW  = SW_W - 1;
  localparam int DW_W = bdbl_pkg::DST_REG_W;
  localparam int DAW  = (MAX_DST_DIM > 1) ? $clog2(MAX_DST_DIM) : 1;
  localparam int AW   = 2 * SW_W;
  localparam int SUM_W = bdbl_pkg::SUM_W;
  localparam int MW   = 3 * SUM_W;
  localparam int DCNT_WC = $clog2(SW_W + 1);

  // configuration registers
  logic [bdbl_pkg::SRC_REG_W-1:0] src_width_r, src_height_r;
  logic [DW_W-1:0]                dst_width_r, dst_height_r;
  logic                           invert_r;

  // derived sizes
  logic [SW_W-1:0] sw, sh;
  logic [DW_W-1:0] dw, dh;
  logic [SW_W-1:0] bw_r, bh_r;
  logic [DW_W-1:0] cstep_r, rstep_r;
  logic [AW-1:0]   area_r;

  // config dividers
  logic [SW_W-1:0]   cq_r, rq_r;
  logic [DW_W-1:0]   cr_r, rr_r;
  logic [DW_W:0]     ct, rt;
  logic [DCNT_WC-1:0] ccnt_r;

  bdbl_pkg::state_t state_r;

  // positions
  logic [SCW-1:0]  scol_r, srow_r, cstart_r, rstart_r;
  logic [DW_W-1:0] ocol_r, orow_r;
  logic [7:0]      crem_r, rrem_r;

  // pixel registers and line store
  logic [7:0]  px_r [3];
  logic        fs_r;
  logic [MW-1:0] sum_mem [MAX_DST_DIM];
  logic [MW-1:0] rd_q;
  logic [DAW-1:0] raddr;

  // pixel divider
  logic [SUM_W-1:0] dq_r [3];
  logic [AW-1:0]    dr_r [3];
  logic [AW:0]      dt   [3];
  logic [bdbl_pkg::DCNT_W-1:0] dcnt_r;

  // output register
  logic        out_valid_r;
  logic [7:0]  avg_r [3];
  logic [1:0]  lvl_r;
  logic        flast_r, flast_pend_r;

  logic in_acc, cfg_acc;

  // --------------------------------------------------------------------------
  // clamped sizes
  always_comb begin
    int lim_w, lim_h;
    if (src_width_r == '0)                     sw = SW_W'(1);
    else if (int'(src_width_r) > MAX_SRC_DIM)  sw = SW_W'(MAX_SRC_DIM);
    else                                       sw = SW_W'(src_width_r);
    if (src_height_r == '0)                    sh = SW_W'(1);
    else if (int'(src_height_r) > MAX_SRC_DIM) sh = SW_W'(MAX_SRC_DIM);
    else                                       sh = SW_W'(src_height_r);
    lim_w = (int'(sw) < MAX_DST_DIM) ? int'(sw) : MAX_DST_DIM;
    lim_h = (int'(sh) < MAX_DST_DIM) ? int'(sh) : MAX_DST_DIM;
    if (dst_width_r == '0)             dw = DW_W'(1);
    else if (int'(dst_width_r) > lim_w) dw = DW_W'(lim_w);
    else                               dw = dst_width_r;
    if (dst_height_r == '0)             dh = DW_W'(1);
    else if (int'(dst_height_r) > lim_h) dh = DW_W'(lim_h);
    else                                dh = dst_height_r;
  end

  // config divider step (restoring, one bit a cycle)
  assign ct = {cr_r, cq_r[SW_W-1]};
  assign rt = {rr_r, rq_r[SW_W-1]};

  // --------------------------------------------------------------------------
  // pixel update, effective positions
  logic [SCW-1:0]  scol, srow, cstart, rstart;
  logic [DW_W-1:0] ocol, orow;
  logic [7:0]      crem, rrem;
  logic [SW_W:0]   cend, rend;
  logic            row_in, row_last, col_hit, col_end, first, emit;
  logic [SUM_W-1:0] nsum [3];
  logic [SCW-1:0]  scol_nxt, srow_nxt, cstart_nxt, rstart_nxt;
  logic [DW_W-1:0] ocol_nxt, orow_nxt, ocol_inc, orow_inc;
  logic [7:0]      crem_nxt, rrem_nxt;
  logic [9:0]      cadv_t, radv_t;
  logic [SW_W:0]   cadv_q, radv_q;
  logic            flast;

  always_comb begin
    scol   = fs_r ? '0 : scol_r;
    srow   = fs_r ? '0 : srow_r;
    cstart = fs_r ? '0 : cstart_r;
    rstart = fs_r ? '0 : rstart_r;
    ocol   = fs_r ? '0 : ocol_r;
    orow   = fs_r ? '0 : orow_r;
    crem   = fs_r ? '0 : crem_r;
    rrem   = fs_r ? '0 : rrem_r;
    cend   = (SW_W+1)'(cstart) + (SW_W+1)'(bw_r);
    rend   = (SW_W+1)'(rstart) + (SW_W+1)'(bh_r);

    row_in   = (orow < dh) && (srow >= rstart) && ((SW_W+1)'(srow) < rend);
    row_last = row_in && ((SW_W+1)'(srow) == rend - (SW_W+1)'(1));
    col_hit  = row_in && (ocol < dw) && (int'(ocol) < MAX_DST_DIM) &&
               (scol >= cstart) && ((SW_W+1)'(scol) < cend);
    col_end  = col_hit && ((SW_W+1)'(scol) == cend - (SW_W+1)'(1));
    first    = (srow == rstart) && (scol == cstart);
    emit     = col_end && row_last;
    flast    = (ocol == dw - DW_W'(1)) && (orow == dh - DW_W'(1));

    for (int i = 0; i < 3; i++) begin
      nsum[i] = first ? SUM_W'(px_r[i])
                      : rd_q[i*SUM_W +: SUM_W] + SUM_W'(px_r[i]);
    end

    // column block advance
    cadv_t = 10'(crem) + 10'(cstep_r);
    cadv_q = (SW_W+1)'(bw_r);
    if (cadv_t >= 10'(dw)) begin
      cadv_t = cadv_t - 10'(dw);
      cadv_q = cadv_q + (SW_W+1)'(1);
    end
    radv_t = 10'(rrem) + 10'(rstep_r);
    radv_q = (SW_W+1)'(bh_r);
    if (radv_t >= 10'(dh)) begin
      radv_t = radv_t - 10'(dh);
      radv_q = radv_q + (SW_W+1)'(1);
    end

    ocol_inc   = ocol + DW_W'(1);
    orow_inc   = orow + DW_W'(1);
    ocol_nxt   = ocol;
    cstart_nxt = cstart;
    crem_nxt   = crem;
    if (col_end) begin
      ocol_nxt = ocol_inc;
      if (ocol_inc < dw) begin
        cstart_nxt = SCW'((SW_W+1)'(cstart) + cadv_q);
        crem_nxt   = cadv_t[7:0];
      end
    end

    scol_nxt   = scol;
    srow_nxt   = srow;
    orow_nxt   = orow;
    rstart_nxt = rstart;
    rrem_nxt   = rrem;
    if ((SW_W)'(scol) >= sw - SW_W'(1)) begin
      scol_nxt   = '0;
      ocol_nxt   = '0;
      cstart_nxt = '0;
      crem_nxt   = '0;
      if ((SW_W)'(srow) >= sh - SW_W'(1)) begin
        srow_nxt   = '0;
        orow_nxt   = '0;
        rstart_nxt = '0;
        rrem_nxt   = '0;
      end else begin
        srow_nxt = srow + SCW'(1);
        if (row_last) begin
          orow_nxt = orow_inc;
          if (orow_inc < dh) begin
            rstart_nxt = SCW'((SW_W+1)'(rstart) + radv_q);
            rrem_nxt   = radv_t[7:0];
          end
        end
      end
    end else begin
      scol_nxt = scol + SCW'(1);
    end
  end

  // pixel divider step
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dt[i] = {dr_r[i], dq_r[i][SUM_W-1]};
    end
  end

  // brightness level of the finished averages
  logic [9:0] lsum;
  logic [1:0] lvl;
  always_comb begin
    lsum = 10'(dq_r[0][7:0]) + 10'(dq_r[1][7:0]) + 10'(dq_r[2][7:0]);
    if (lsum <= bdbl_pkg::LVL_T1)      lvl = 2'd0;
    else if (lsum <= bdbl_pkg::LVL_T2) lvl = 2'd1;
    else if (lsum <= bdbl_pkg::LVL_T3) lvl = 2'd2;
    else                               lvl = bdbl_pkg::LVL_MAX;
    if (invert_r) lvl = bdbl_pkg::LVL_MAX - lvl;
  end

  // --------------------------------------------------------------------------
  // handshakes
  assign cfg_ready = (state_r == bdbl_pkg::S_IDLE);
  assign in_tready = (state_r == bdbl_pkg::S_IDLE) && !cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign raddr     = in_tuser ? '0 : DAW'(ocol_r);

  // line store: read on accept, write back in the update cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_q <= sum_mem[raddr];
    end
    if (state_r == bdbl_pkg::S_UPD && col_hit) begin
      sum_mem[DAW'(ocol)] <= {nsum[2], nsum[1], nsum[0]};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= bdbl_pkg::SRC_REG_W'(1);
      src_height_r <= bdbl_pkg::SRC_REG_W'(1);
      dst_width_r  <= DW_W'(1);
      dst_height_r <= DW_W'(1);
      invert_r     <= 1'b0;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        bdbl_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_data;
        bdbl_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_data;
        bdbl_pkg::REG_DST_WIDTH:  dst_width_r  <= cfg_data[DW_W-1:0];
        bdbl_pkg::REG_DST_HEIGHT: dst_height_r <= cfg_data[DW_W-1:0];
        bdbl_pkg::REG_INVERT:     invert_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer, positions, dividers, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bdbl_pkg::S_IDLE;
      bw_r         <= SW_W'(1);
      bh_r         <= SW_W'(1);
      cstep_r      <= '0;
      rstep_r      <= '0;
      area_r       <= AW'(1);
      scol_r       <= '0;
      srow_r       <= '0;
      cstart_r     <= '0;
      rstart_r     <= '0;
      ocol_r       <= '0;
      orow_r       <= '0;
      crem_r       <= '0;
      rrem_r       <= '0;
      out_valid_r  <= 1'b0;
      ccnt_r       <= '0;
      dcnt_r       <= '0;
    end else begin
      // a reload in S_OUT sets valid itself
      if (out_valid_r && out_tready && state_r != bdbl_pkg::S_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        bdbl_pkg::S_IDLE: begin
          if (cfg_acc) begin
            state_r <= bdbl_pkg::S_CLD;
          end else if (in_acc) begin
            px_r[0] <= in_tdata[7:0];
            px_r[1] <= in_tdata[15:8];
            px_r[2] <= in_tdata[23:16];
            fs_r    <= in_tuser;
            state_r <= bdbl_pkg::S_UPD;
          end
        end
        bdbl_pkg::S_UPD: begin
          scol_r   <= scol_nxt;
          srow_r   <= srow_nxt;
          cstart_r <= cstart_nxt;
          rstart_r <= rstart_nxt;
          ocol_r   <= ocol_nxt;
          orow_r   <= orow_nxt;
          crem_r   <= crem_nxt;
          rrem_r   <= rrem_nxt;
          if (emit) begin
            for (int i = 0; i < 3; i++) begin
              dq_r[i] <= nsum[i];
              dr_r[i] <= '0;
            end
            flast_pend_r <= flast;
            dcnt_r       <= '0;
            state_r      <= bdbl_pkg::S_DIV;
          end else begin
            state_r <= bdbl_pkg::S_IDLE;
          end
        end
        bdbl_pkg::S_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (dt[i] >= (AW+1)'(area_r)) begin
              dr_r[i] <= AW'(dt[i] - (AW+1)'(area_r));
              dq_r[i] <= {dq_r[i][SUM_W-2:0], 1'b1};
            end else begin
              dr_r[i] <= dt[i][AW-1:0];
              dq_r[i] <= {dq_r[i][SUM_W-2:0], 1'b0};
            end
          end
          dcnt_r <= dcnt_r + bdbl_pkg::DCNT_W'(1);
          if (dcnt_r == bdbl_pkg::DCNT_W'(bdbl_pkg::DIV_STEPS - 1)) begin
            state_r <= bdbl_pkg::S_OUT;
          end
        end
        bdbl_pkg::S_OUT: begin
          if (!out_valid_r || out_tready) begin
            for (int i = 0; i < 3; i++) avg_r[i] <= dq_r[i][7:0];
            lvl_r       <= lvl;
            flast_r     <= flast_pend_r;
            out_valid_r <= 1'b1;
            state_r     <= bdbl_pkg::S_IDLE;
          end
        end
        bdbl_pkg::S_CLD: begin
          cq_r    <= sw;
          rq_r    <= sh;
          cr_r    <= '0;
          rr_r    <= '0;
          ccnt_r  <= '0;
          state_r <= bdbl_pkg::S_CDIV;
        end
        bdbl_pkg::S_CDIV: begin
          if (ct >= (DW_W+1)'(dw)) begin
            cr_r <= DW_W'(ct - (DW_W+1)'(dw));
            cq_r <= {cq_r[SW_W-2:0], 1'b1};
          end else begin
            cr_r <= ct[DW_W-1:0];
            cq_r <= {cq_r[SW_W-2:0], 1'b0};
          end
          if (rt >= (DW_W+1)'(dh)) begin
            rr_r <= DW_W'(rt - (DW_W+1)'(dh));
            rq_r <= {rq_r[SW_W-2:0], 1'b1};
          end else begin
            rr_r <= rt[DW_W-1:0];
            rq_r <= {rq_r[SW_W-2:0], 1'b0};
          end
          ccnt_r <= ccnt_r + DCNT_WC'(1);
          if (ccnt_r == DCNT_WC'(SW_W - 1)) begin
            state_r <= bdbl_pkg::S_AREA;
          end
        end
        bdbl_pkg::S_AREA: begin
          bw_r    <= cq_r;
          bh_r    <= rq_r;
          cstep_r <= cr_r;
          rstep_r <= rr_r;
          area_r  <= AW'(cq_r) * AW'(rq_r);
          state_r <= bdbl_pkg::S_IDLE;
        end
        default: state_r <= bdbl_pkg::S_IDLE;
      endcase
    end
  end

  // output port
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, lvl_r, avg_r[2], avg_r[1], avg_r[0]};
  assign out_tlast  = flast_r;

endmodule

@@ hw/rtl/bdbl_checker.sv @@
// ----------------------------------------------------------------------------
// bdbl_checker
// Port-level checks of the box downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module bdbl_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic cfg_valid,
  input logic cfg_ready
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // reset leaves no result word pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // an accepted pixel occupies the update cycle
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !cfg_ready)
    else $error("pixel taken during update cycle");

  // a register write starts the size recompute
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready && !cfg_ready)
    else $error("input taken during size recompute");

endmodule

bind box_downscale_brightness_level bdbl_checker u_bdbl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
